// ===== design/ffrp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the first-fit rectangle placer: widths, codes, payload types.
// No dependencies.
package ffrp_pkg;

    localparam int COORD_BITS   = 16;
    localparam int SIZE_BITS    = COORD_BITS - 1;
    localparam int POS_BITS     = COORD_BITS + 2;
    localparam int ENTRY_BITS   = 2 * COORD_BITS + 2 * SIZE_BITS;
    localparam int MAX_RECTS_DEF = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [POS_BITS-1:0] COORD_MAX = POS_BITS'((1 << (COORD_BITS - 1)) - 1);

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_PLACE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic SCAN_ROWS_FIRST = 1'b0;
    localparam logic SCAN_COLS_FIRST = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCAN_ORDER  = 3'd4;

    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [COORD_BITS-1:0] rect_x;
        logic signed [COORD_BITS-1:0] rect_y;
        logic [SIZE_BITS-1:0]        rect_w;
        logic [SIZE_BITS-1:0]        rect_h;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [COORD_BITS-1:0] place_x;
        logic signed [COORD_BITS-1:0] place_y;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] area_left;
        logic signed [COORD_BITS-1:0] area_top;
        logic [SIZE_BITS-1:0]        area_width;
        logic [SIZE_BITS-1:0]        area_height;
        logic                        scan_order;
    } t_area_cfg;

    typedef struct packed {
        logic ready;
        logic done;
    } t_seq_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUTER,
        S_BRD,
        S_BCK,
        S_FIT,
        S_ERD,
        S_ECK,
        S_DONE
    } t_seq_state;

endpackage

// ===== design/ffrp_rect_mem.sv =====
`timescale 1ns / 1ps
// Rectangle store: one write port, one read port with registered read data.
// Uses ffrp_pkg for the entry width.
module ffrp_rect_mem #(
    parameter int MAX_RECTS = ffrp_pkg::MAX_RECTS_DEF,
    parameter int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [AW-1:0]                   i_waddr,
    input  logic [ffrp_pkg::ENTRY_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                   i_raddr,
    output logic [ffrp_pkg::ENTRY_BITS-1:0] o_rdata
);
    import ffrp_pkg::*;

    logic [ENTRY_BITS-1:0] r_mem [MAX_RECTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/ffrp_seq.sv =====
`timescale 1ns / 1ps
// Placement sequencer: walks the rectangle store for overlap and edge scans.
// Uses ffrp_pkg and instantiates ffrp_rect_mem.
module ffrp_seq #(
    parameter int MAX_RECTS = ffrp_pkg::MAX_RECTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ffrp_pkg::t_in_item    i_item,
    input  logic                  i_take,
    input  ffrp_pkg::t_area_cfg   i_cfg,
    output ffrp_pkg::t_seq_status o_status,
    output ffrp_pkg::t_out_item   o_result
);
    import ffrp_pkg::*;

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int CB = COORD_BITS;
    localparam int SB = SIZE_BITS;
    localparam int PB = POS_BITS;

    t_seq_state r_state, n_state;

    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_k, n_k;
    logic signed [PB-1:0] r_po, n_po;   // outer-axis position
    logic signed [PB-1:0] r_pi, n_pi;   // inner-axis position
    logic signed [PB-1:0] r_e, n_e;
    logic [SB-1:0]        r_w, n_w;
    logic [SB-1:0]        r_h, n_h;
    t_out_item            r_res, n_res;

    logic                  mem_we;
    logic [ENTRY_BITS-1:0] mem_wdata;
    logic [ENTRY_BITS-1:0] mem_rdata;

    ffrp_rect_mem #(.MAX_RECTS(MAX_RECTS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Axis mapping: rows first keeps y outer, columns first keeps x outer.
    logic                 col_first;
    logic signed [PB-1:0] left_e, top_e, lim_x, lim_y;
    logic signed [PB-1:0] org_o, org_i, lim_o, lim_i, sz_o, sz_i;
    logic signed [PB-1:0] ent_x, ent_y, ent_w, ent_h;
    logic signed [PB-1:0] ent_o, ent_i, ext_o, ext_i, end_o, end_i;
    logic                 overlap, inner_room, fits, count_full;

    always_comb begin
        col_first = (i_cfg.scan_order == SCAN_COLS_FIRST);
        left_e = PB'(i_cfg.area_left);
        top_e  = PB'(i_cfg.area_top);
        lim_x  = left_e + signed'({{(PB-SB){1'b0}}, i_cfg.area_width});
        lim_y  = top_e + signed'({{(PB-SB){1'b0}}, i_cfg.area_height});
        org_o  = col_first ? left_e : top_e;
        org_i  = col_first ? top_e : left_e;
        lim_o  = col_first ? lim_x : lim_y;
        lim_i  = col_first ? lim_y : lim_x;
        sz_o   = signed'({{(PB-SB){1'b0}}, (col_first ? r_w : r_h)});
        sz_i   = signed'({{(PB-SB){1'b0}}, (col_first ? r_h : r_w)});

        ent_x = PB'(signed'(mem_rdata[ENTRY_BITS-1 -: CB]));
        ent_y = PB'(signed'(mem_rdata[ENTRY_BITS-CB-1 -: CB]));
        ent_w = signed'({{(PB-SB){1'b0}}, mem_rdata[2*SB-1 -: SB]});
        ent_h = signed'({{(PB-SB){1'b0}}, mem_rdata[SB-1:0]});
        ent_o = col_first ? ent_x : ent_y;
        ent_i = col_first ? ent_y : ent_x;
        ext_o = col_first ? ent_w : ent_h;
        ext_i = col_first ? ent_h : ent_w;
        end_o = ent_o + ext_o;
        end_i = ent_i + ext_i;

        overlap = (r_po < end_o) && (r_pi < end_i) &&
                  (r_po + sz_o > ent_o) && (r_pi + sz_i > ent_i);
        inner_room = (r_pi + sz_i < lim_i);
        fits = inner_room && (r_po + sz_o < lim_o) &&
               (r_po <= signed'(COORD_MAX)) && (r_pi <= signed'(COORD_MAX));
        count_full = (r_count == CW'(MAX_RECTS));
        mem_wdata = {i_item.rect_x, i_item.rect_y, i_item.rect_w, i_item.rect_h};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_item.mode == MODE_PLACE) ? S_OUTER : S_DONE;
                end
            end
            S_OUTER: n_state = (r_po < lim_o) ? S_BRD : S_DONE;
            S_BRD:   n_state = (r_k == r_count) ? S_FIT : S_BCK;
            S_BCK: begin
                if (overlap && !inner_room) begin
                    n_state = S_FIT;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_FIT:   n_state = fits ? S_DONE : S_ERD;
            S_ERD:   n_state = (r_k == r_count) ? S_OUTER : S_ECK;
            S_ECK:   n_state = S_ERD;
            S_DONE:  n_state = i_take ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_count = r_count;
        n_k     = r_k;
        n_po    = r_po;
        n_pi    = r_pi;
        n_e     = r_e;
        n_w     = r_w;
        n_h     = r_h;
        n_res   = r_res;
        mem_we  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_w   = i_item.rect_w;
                    n_h   = i_item.rect_h;
                    n_po  = org_o;
                    n_pi  = org_i;
                    n_res = '{status: ST_OK, place_x: '0, place_y: '0};
                    case (i_item.mode)
                        MODE_CLEAR: n_count = '0;
                        MODE_ADD: begin
                            if (count_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OUTER: begin
                n_k = '0;
                if (!(r_po < lim_o)) begin
                    n_res.status = ST_NOSPACE;
                end
            end
            S_BCK: begin
                if (overlap && inner_room) begin
                    n_pi = end_i + 1'b1;
                    n_k  = '0;
                end else if (!overlap) begin
                    n_k = r_k + 1'b1;
                end
            end
            S_FIT: begin
                n_k = '0;
                n_e = lim_o;
                if (fits) begin
                    n_res.place_x = CB'(col_first ? r_po : r_pi);
                    n_res.place_y = CB'(col_first ? r_pi : r_po);
                end
            end
            S_ERD: begin
                if (r_k == r_count) begin
                    n_po = r_e + 1'b1;
                    n_pi = org_i;
                end
            end
            S_ECK: begin
                if (end_o > r_po && end_o < r_e) begin
                    n_e = end_o;
                end
                n_k = r_k + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_po  <= n_po;
        r_pi  <= n_pi;
        r_e   <= n_e;
        r_w   <= n_w;
        r_h   <= n_h;
        r_res <= n_res;
    end

    assign o_status = '{ready: (r_state == S_IDLE), done: (r_state == S_DONE)};
    assign o_result = r_res;

endmodule

// ===== design/first_fit_rectangle_placer_top.sv =====
`timescale 1ns / 1ps
// Top level of the first-fit rectangle placer: handshakes, config registers,
// output register. Uses ffrp_pkg and instantiates ffrp_seq.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Clear and add go straight to the done state. A place request makes overlap
// passes and edge passes over the N stored rectangles, paced by the single
// read port of the rectangle store, with a read and a check state per entry.
// Reset is synchronous; the store needs no clearing pass.
// Output stall holds the result register; one more item is taken meanwhile.
module first_fit_rectangle_placer_top #(
    parameter int MAX_RECTS = ffrp_pkg::MAX_RECTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ffrp_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ffrp_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ffrp_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ffrp_pkg::COORD_BITS-1:0]       i_cfg_data
);
    import ffrp_pkg::*;

    t_area_cfg   r_cfg;
    t_seq_status seq_st;
    t_out_item   seq_res;
    t_out_item   r_out;
    logic        r_out_valid;
    logic        take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !seq_st.ready;
    assign take        = seq_st.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{area_left: '0, area_top: '0, area_width: SIZE_BITS'(1024),
                       area_height: SIZE_BITS'(768), scan_order: SCAN_ROWS_FIRST};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AREA_LEFT:   r_cfg.area_left   <= i_cfg_data;
                CFG_AREA_TOP:    r_cfg.area_top    <= i_cfg_data;
                CFG_AREA_WIDTH:  r_cfg.area_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_AREA_HEIGHT: r_cfg.area_height <= i_cfg_data[SIZE_BITS-1:0];
                CFG_SCAN_ORDER:  r_cfg.scan_order  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ffrp_seq #(.MAX_RECTS(MAX_RECTS)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && seq_st.ready),
        .i_item   (i_in_data),
        .i_take   (take),
        .i_cfg    (r_cfg),
        .o_status (seq_st),
        .o_result (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_rectangle_placer_top: an in-bench
// predictor of the rectangle table and first-fit scan checks each result.
// Depends on ffrp_pkg and the placer RTL.
module tb_top;
    import ffrp_pkg::*;

    localparam int NRECT = 16;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    o_in_stall;
    t_in_item                in_data = '0;
    logic                    o_out_valid;
    logic                    out_stall = 1'b0;
    t_out_item               o_out_data;
    logic                    cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0]   cfg_data = '0;

    first_fit_rectangle_placer_top #(.MAX_RECTS(NRECT)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // predictor state
    longint    ws_left = 0, ws_top = 0, ws_width = 1024, ws_height = 768;
    bit        col_first = 1'b0;
    longint    box_org[NRECT][2];
    longint    box_ext[NRECT][2];
    int        box_count = 0;

    t_in_item  item_q[$];
    t_out_item result_q[$];
    int        burst_left = 0, gap_left = 0;
    int        n_taken = 0;
    int        n_errors = 0;
    int        hold_cnt = 0, stall_phase = 0, stall_kind = 0;
    bit        long_hold_done = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int first_blocker(longint pos[2], longint sz[2]);
        for (int k = 0; k < box_count; k++) begin
            if (pos[0] >= box_org[k][0] + box_ext[k][0]) continue;
            if (pos[1] >= box_org[k][1] + box_ext[k][1]) continue;
            if (pos[0] + sz[0] <= box_org[k][0]) continue;
            if (pos[1] + sz[1] <= box_org[k][1]) continue;
            return k;
        end
        return -1;
    endfunction

    function automatic bit scan_fit(longint w, longint h, output longint px, output longint py);
        longint org[2], lim[2], sz[2], pos[2];
        longint e, fe;
        int o, i, b;
        o = col_first ? 0 : 1;
        i = 1 - o;
        org[0] = ws_left; org[1] = ws_top;
        lim[0] = ws_left + ws_width; lim[1] = ws_top + ws_height;
        sz[0] = w; sz[1] = h;
        pos[0] = org[0]; pos[1] = org[1];
        px = 0; py = 0;
        while (pos[o] < lim[o]) begin
            b = first_blocker(pos, sz);
            while (b >= 0 && pos[i] + sz[i] < lim[i]) begin
                pos[i] = box_org[b][i] + box_ext[b][i] + 1;
                b = first_blocker(pos, sz);
            end
            if (pos[0] + sz[0] < lim[0] && pos[1] + sz[1] < lim[1] &&
                pos[0] <= 32767 && pos[1] <= 32767) begin
                px = pos[0]; py = pos[1];
                return 1'b1;
            end
            e = lim[o];
            for (int k = 0; k < box_count; k++) begin
                fe = box_org[k][o] + box_ext[k][o];
                if (fe > pos[o] && fe < e) e = fe;
            end
            pos[o] = e + 1;
            pos[i] = org[i];
        end
        return 1'b0;
    endfunction

    function automatic t_out_item placer_result(t_in_item it);
        t_out_item r;
        longint px, py;
        r = '0;
        case (it.mode)
            MODE_CLEAR: box_count = 0;
            MODE_ADD: begin
                if (box_count >= NRECT) begin
                    r.status = ST_FULL;
                end else begin
                    box_org[box_count][0] = longint'($signed(it.rect_x));
                    box_org[box_count][1] = longint'($signed(it.rect_y));
                    box_ext[box_count][0] = longint'(it.rect_w);
                    box_ext[box_count][1] = longint'(it.rect_h);
                    box_count++;
                end
            end
            MODE_PLACE: begin
                if (scan_fit(longint'(it.rect_w), longint'(it.rect_h), px, py)) begin
                    r.place_x = 16'(px);
                    r.place_y = 16'(py);
                end else begin
                    r.status = ST_NOSPACE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                result_q.push_back(placer_result(in_data));
                n_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    in_data <= item_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else if (!long_hold_done && n_taken >= 400) begin
            long_hold_done = 1'b1;
            hold_cnt = 3000;
            out_stall <= 1'b1;
        end else begin
            stall_phase++;
            if (stall_phase >= 97) begin
                stall_phase = 0;
                stall_kind = $urandom_range(0, 2);
            end
            case (stall_kind)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                want = result_q.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_out_data.status);
                    n_errors++;
                end
                if (o_out_data.place_x !== want.place_x) begin
                    $error("place_x exp %0d got %0d", want.place_x, o_out_data.place_x);
                    n_errors++;
                end
                if (o_out_data.place_y !== want.place_y) begin
                    $error("place_y exp %0d got %0d", want.place_y, o_out_data.place_y);
                    n_errors++;
                end
            end
        end
    end

    // sample after the edge so the driver and checker have settled
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (item_q.size() != 0 || in_valid || result_q.size() != 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_AREA_LEFT:   ws_left = longint'($signed(val));
            CFG_AREA_TOP:    ws_top = longint'($signed(val));
            CFG_AREA_WIDTH:  ws_width = longint'(val[SIZE_BITS-1:0]);
            CFG_AREA_HEIGHT: ws_height = longint'(val[SIZE_BITS-1:0]);
            CFG_SCAN_ORDER:  col_first = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic [1:0] m, longint x, longint y, longint w, longint h);
        t_in_item it;
        it.mode = m;
        it.rect_x = 16'(x);
        it.rect_y = 16'(y);
        it.rect_w = 15'(w);
        it.rect_h = 15'(h);
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        return it;
    endfunction

    // rectangle roughly inside the current workspace
    function automatic t_in_item area_rect(logic [1:0] m);
        longint aw, ah;
        aw = (ws_width > 0) ? ws_width : 1;
        ah = (ws_height > 0) ? ws_height : 1;
        return mk(m, ws_left + $urandom_range(0, 32'(aw)) - 2,
                  ws_top + $urandom_range(0, 32'(ah)) - 2,
                  $urandom_range(0, 32'(aw / 3 + 1)), $urandom_range(0, 32'(ah / 3 + 1)));
    endfunction

    initial begin
        int nadd, nplace, r, total;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset configuration
        item_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));
        item_q.push_back(mk(MODE_UNUSED, -1, -1, 32767, 32767));
        item_q.push_back(mk(MODE_PLACE, 0, 0, 0, 0));
        item_q.push_back(mk(MODE_PLACE, 0, 0, 32767, 32767));
        item_q.push_back(mk(MODE_ADD, -32768, -32768, 32767, 32767));
        item_q.push_back(mk(MODE_PLACE, 0, 0, 10, 10));
        item_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));
        for (int k = 0; k < NRECT; k++)
            item_q.push_back(mk(MODE_ADD, k * 60, (k % 4) * 150, 50 + k, 100 - k));
        item_q.push_back(mk(MODE_ADD, 32767, 32767, 0, 0));
        item_q.push_back(mk(MODE_PLACE, 0, 0, 8, 8));
        item_q.push_back(mk(MODE_PLACE, 0, 0, 300, 300));
        wait_drained();

        total = 0;
        for (int ph = 0; total < 1950; ph++) begin
            // idle: every result is back
            case (ph % 6)
                0: begin
                    write_reg(CFG_AREA_LEFT, 16'h8000);
                    write_reg(CFG_AREA_TOP, 16'h8000);
                    write_reg(CFG_AREA_WIDTH, 16'h7fff);
                    write_reg(CFG_AREA_HEIGHT, 16'h7fff);
                    write_reg(CFG_SCAN_ORDER, 16'h0001);
                end
                1: begin
                    write_reg(CFG_AREA_LEFT, 16'h7f00);
                    write_reg(CFG_AREA_TOP, 16'h7fff);
                    write_reg(CFG_AREA_WIDTH, 16'hffff);
                    write_reg(CFG_AREA_HEIGHT, 16'h0000);
                    write_reg(CFG_SCAN_ORDER, 16'hfffe);
                    write_reg(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom));
                end
                2: begin
                    write_reg(CFG_AREA_HEIGHT, 16'h0100);
                    write_reg(CFG_AREA_WIDTH, 16'h0000);
                end
                default: begin
                    write_reg(CFG_AREA_LEFT, 16'($signed(16'($urandom)) >>> $urandom_range(0, 15)));
                    write_reg(CFG_AREA_TOP, 16'($signed(16'($urandom)) >>> $urandom_range(0, 15)));
                    write_reg(CFG_AREA_WIDTH, 16'($urandom_range(16, 2048)));
                    write_reg(CFG_AREA_HEIGHT, 16'($urandom_range(16, 2048)));
                    write_reg(CFG_SCAN_ORDER, 16'($urandom));
                end
            endcase

            for (int s = 0; s < 60 && total < 1950; s++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    item_q.push_back(noise_item());
                    total++;
                    continue;
                end
                item_q.push_back(mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom));
                r = $urandom_range(0, 99);
                nadd = (r < 70) ? $urandom_range(0, 4) :
                       (r < 95) ? $urandom_range(5, 10) : $urandom_range(14, 18);
                for (int a = 0; a < nadd; a++)
                    item_q.push_back(area_rect(MODE_ADD));
                nplace = $urandom_range(1, 4);
                for (int p = 0; p < nplace; p++)
                    item_q.push_back(area_rect(MODE_PLACE));
                total += 1 + nadd + nplace;
            end
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
